@@ hw/rtl/sha1_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants of the SHA-1 hash engine: request and result
// structs, command codes, initial chain value and round constants.
// ----------------------------------------------------------------------------
package sha1_pkg;

  // input opcodes
  localparam logic [1:0] OP_INIT   = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  // default depth of the command queue between front and back
  localparam int CMD_DEPTH = 4;

  // compression rounds
  localparam int ROUNDS = 80;
  localparam int RW     = $clog2(ROUNDS);

  // standard initial chain value
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hc3d2e1f0;

  // round constants, one per group of twenty rounds
  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  // padding marker byte
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // request on the input channel
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
  } in_item_t;

  // result on the output channel
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // classified command held in the queue
  typedef enum logic [1:0] {
    CMD_INIT,
    CMD_APPEND,
    CMD_FINISH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  // 64-byte message block, byte 3 of each word is the most significant
  typedef logic [15:0][3:0][7:0] blk_t;

  // five-word chain value, index 0 is word a
  typedef logic [4:0][31:0] chain_t;

  // compression unit status
  typedef struct packed {
    logic busy;
    logic done;
  } cmp_stat_t;

  function automatic chain_t iv_chain();
    chain_t c;
    c[0] = IV0;
    c[1] = IV1;
    c[2] = IV2;
    c[3] = IV3;
    c[4] = IV4;
    return c;
  endfunction

endpackage

@@ hw/rtl/sha1_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_front
// Takes requests, decodes the opcode into a command and keeps the commands
// in a short queue for the back end. Unused opcodes are taken and dropped.
// ----------------------------------------------------------------------------
module sha1_front
  import sha1_pkg::*;
#(
  parameter int CmdDepth = CMD_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_item,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_take
);

  localparam int IW = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
  localparam int CW = $clog2(CmdDepth + 1);

  cmd_t          q_r [CmdDepth];
  logic [IW-1:0] wp_r, wp_nxt;
  logic [IW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic accept;
  logic is_cmd;
  logic enq;
  logic deq;
  cmd_t dec;

  // opcode decode
  always_comb begin
    dec.data = in_item.data_byte;
    dec.kind = CMD_APPEND;
    is_cmd   = 1'b1;
    case (in_item.opcode)
      OP_INIT:   dec.kind = CMD_INIT;
      OP_APPEND: dec.kind = CMD_APPEND;
      OP_FINISH: dec.kind = CMD_FINISH;
      default:   is_cmd   = 1'b0;
    endcase
  end

  assign in_full   = (cnt_r == CW'(CmdDepth));
  assign accept    = in_push && !in_full;
  assign enq       = accept && is_cmd;
  assign cmd_valid = (cnt_r != '0);
  assign deq       = cmd_take && cmd_valid;
  assign cmd       = q_r[rp_r];

  // pointer and count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (enq) begin
      wp_nxt = (wp_r == IW'(CmdDepth - 1)) ? '0 : wp_r + 1'b1;
    end
    if (deq) begin
      rp_nxt = (rp_r == IW'(CmdDepth - 1)) ? '0 : rp_r + 1'b1;
    end
    case ({enq, deq})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wp_r] <= dec;
    end
  end

endmodule

@@ hw/rtl/sha1_compress.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_compress
// SHA-1 compression of one 64-byte block, one round per cycle, with the
// message schedule kept in a 16-word shift line. Gives the folded chain
// value in the cycle after the last round.
// ----------------------------------------------------------------------------
module sha1_compress
  import sha1_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  blk_t      blk,
  input  chain_t    chain_in,
  output cmp_stat_t stat,
  output chain_t    sum
);

  logic [15:0][31:0] s_r, s_nxt;
  chain_t            v_r, v_nxt;
  chain_t            h_r;
  logic [RW-1:0]     cnt_r;
  logic              run_r;
  logic              done_r;

  logic [31:0] a, b, c, d, e;
  logic [31:0] f, k, tmp, w_new;

  assign a = v_r[0];
  assign b = v_r[1];
  assign c = v_r[2];
  assign d = v_r[3];
  assign e = v_r[4];

  // round function and constant by round group
  always_comb begin
    if (cnt_r < RW'(20)) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (cnt_r < RW'(40)) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (cnt_r < RW'(60)) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  // one round plus schedule step
  always_comb begin
    tmp   = {a[26:0], a[31:27]} + f + e + s_r[0] + k;
    w_new = s_r[13] ^ s_r[8] ^ s_r[2] ^ s_r[0];
    v_nxt[0] = tmp;
    v_nxt[1] = a;
    v_nxt[2] = {b[1:0], b[31:2]};
    v_nxt[3] = c;
    v_nxt[4] = d;
    for (int i = 0; i < 15; i++) begin
      s_nxt[i] = s_r[i+1];
    end
    s_nxt[15] = {w_new[30:0], w_new[31]};
  end

  // fold the working variables into the chain value
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      sum[i] = h_r[i] + v_r[i];
    end
  end

  assign stat.busy = run_r || done_r;
  assign stat.done = done_r;

  // round sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == RW'(ROUNDS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // working variables and schedule
  always_ff @(posedge clk) begin
    if (start) begin
      v_r <= chain_in;
      h_r <= chain_in;
      for (int i = 0; i < 16; i++) begin
        s_r[i] <= blk[i];
      end
    end else if (run_r) begin
      v_r <= v_nxt;
      s_r <= s_nxt;
    end
  end

endmodule

@@ hw/rtl/sha1_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_back
// Carries out queued commands: packs bytes into the block buffer, counts the
// message length, pads on finish, hands full blocks to the compression unit
// and holds the finished digest in an output shift register.
// ----------------------------------------------------------------------------
module sha1_back
  import sha1_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_take,
  output logic      cmp_start,
  output blk_t      cmp_blk,
  output chain_t    cmp_chain,
  input  cmp_stat_t cmp_stat,
  input  chain_t    cmp_sum,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PAD,
    S_LAST,
    S_EMIT
  } state_t;

  state_t       state_r, state_nxt;
  logic [5:0]   pos_r, pos_nxt;
  logic [63:0]  len_r, len_nxt;
  chain_t       chain_r, chain_nxt;
  logic         full_r, full_nxt;
  logic         ovld_r, ovld_nxt;
  logic [2:0]   oidx_r, oidx_nxt;
  blk_t         blk_r, blk_nxt;
  chain_t       dig_r, dig_nxt;

  logic         wr_en;
  logic [7:0]   wr_val;

  assign cmp_blk   = blk_r;
  assign cmp_chain = chain_r;
  assign out_empty = !ovld_r;

  assign out_item.digest_word = dig_r[0];
  assign out_item.word_index  = oidx_r;
  assign out_item.last_word   = (oidx_r == 3'd4);

  // command sequencing
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    chain_nxt = chain_r;
    full_nxt  = full_r;
    ovld_nxt  = ovld_r;
    oidx_nxt  = oidx_r;
    blk_nxt   = blk_r;
    dig_nxt   = dig_r;
    cmd_take  = 1'b0;
    wr_en     = 1'b0;
    wr_val    = '0;

    // launch a full block once the round unit is free
    cmp_start = full_r && !cmp_stat.busy;
    if (cmp_start) begin
      full_nxt = 1'b0;
    end

    // fold result back into the chain value
    if (cmp_stat.done) begin
      chain_nxt = cmp_sum;
    end

    // digest word drained
    if (ovld_r && out_pop) begin
      for (int i = 0; i < 4; i++) begin
        dig_nxt[i] = dig_r[i+1];
      end
      oidx_nxt = oidx_r + 1'b1;
      if (oidx_r == 3'd4) begin
        ovld_nxt = 1'b0;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            CMD_APPEND: begin
              if (!full_r) begin
                cmd_take = 1'b1;
                wr_en    = 1'b1;
                wr_val   = cmd.data;
                len_nxt  = len_r + 64'd8;
              end
            end
            CMD_INIT: begin
              if (!full_r && !cmp_stat.busy) begin
                cmd_take  = 1'b1;
                chain_nxt = iv_chain();
                pos_nxt   = '0;
                len_nxt   = '0;
              end
            end
            CMD_FINISH: begin
              if (!full_r && !cmp_stat.busy) begin
                cmd_take  = 1'b1;
                wr_en     = 1'b1;
                wr_val    = PAD_BYTE;
                state_nxt = S_PAD;
              end
            end
            default: begin
              cmd_take = 1'b0;
            end
          endcase
        end
      end
      S_PAD: begin
        // zero fill up to the length field, then place the bit count
        if (!full_r) begin
          if (pos_r == 6'd56) begin
            blk_nxt[14] = len_r[63:32];
            blk_nxt[15] = len_r[31:0];
            full_nxt    = 1'b1;
            state_nxt   = S_LAST;
          end else begin
            wr_en = 1'b1;
          end
        end
      end
      S_LAST: begin
        if (!full_r && !cmp_stat.busy) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!ovld_r) begin
          dig_nxt   = chain_r;
          oidx_nxt  = '0;
          ovld_nxt  = 1'b1;
          chain_nxt = iv_chain();
          pos_nxt   = '0;
          len_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // byte write into the block buffer, big-endian within a word
    if (wr_en) begin
      blk_nxt[pos_r[5:2]][~pos_r[1:0]] = wr_val;
      pos_nxt = pos_r + 1'b1;
      if (pos_r == 6'd63) begin
        full_nxt = 1'b1;
      end
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= '0;
      len_r   <= '0;
      chain_r <= iv_chain();
      full_r  <= 1'b0;
      ovld_r  <= 1'b0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      chain_r <= chain_nxt;
      full_r  <= full_nxt;
      ovld_r  <= ovld_nxt;
      oidx_r  <= oidx_nxt;
    end
  end

  // block buffer and digest words
  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    dig_r <= dig_nxt;
  end

endmodule

@@ hw/rtl/sha1_hash_engine_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_hash_engine_unit
// SHA-1 hash engine taking one message byte per request and giving the
// 160-bit digest as five 32-bit result words.
// ----------------------------------------------------------------------------
// Requests pass through a short command queue to the back end, which packs an
// append byte into the block buffer. A full 64-byte block is handed to the
// single round unit, which runs one round per cycle and holds it while it
// loads, runs the 80 rounds and folds; the next block fills meanwhile. Init
// waits for a running compression to end. Finish pads one byte per cycle
// while the block buffer is not full, runs one or two compressions and then
// loads the five digest words into the result queue, word 0 first; the
// digest of a further finish is loaded only once the previous digest has
// been drained. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sha1_hash_engine_unit
  import sha1_pkg::*;
#(
  parameter int CmdDepth = CMD_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  logic      cmd_valid;
  cmd_t      cmd;
  logic      cmd_take;
  logic      cmp_start;
  blk_t      cmp_blk;
  chain_t    cmp_chain;
  cmp_stat_t cmp_stat;
  chain_t    cmp_sum;

  // request decode and queue
  sha1_front #(
    .CmdDepth (CmdDepth)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // command execution and digest output
  sha1_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .cmp_start (cmp_start),
    .cmp_blk   (cmp_blk),
    .cmp_chain (cmp_chain),
    .cmp_stat  (cmp_stat),
    .cmp_sum   (cmp_sum),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  // round unit
  sha1_compress u_compress (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmp_start),
    .blk      (cmp_blk),
    .chain_in (cmp_chain),
    .stat     (cmp_stat),
    .sum      (cmp_sum)
  );

endmodule

@@ hw/rtl/sha1_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_chk
// Port-level checks of the hash engine: result queue empties on reset and
// digest words come out in order, flagged correctly.
// ----------------------------------------------------------------------------
module sha1_chk
  import sha1_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_push,
  input logic      in_full,
  input in_item_t  in_item,
  input logic      out_empty,
  input logic      out_pop,
  input out_item_t out_item
);

  // no result is shown right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // last flag marks exactly the fifth word
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_item.last_word == (out_item.word_index == 3'd4)))
    else $error("last_word does not match word_index");

  // words of one digest follow each other in order
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_item.last_word) |=>
      (!out_empty &&
       out_item.word_index == 3'($past(out_item.word_index) + 3'd1)))
    else $error("digest word missing or out of order");

  // a new digest starts at word zero
  a_index_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && out_item.last_word) |=>
      (out_empty || out_item.word_index == 3'd0))
    else $error("digest does not start at word zero");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("waiting result changed before it was taken");

endmodule

bind sha1_hash_engine_unit sha1_chk u_chk (.*);
